// ===== hw/rtl/mksl_pkg.sv =====
package mksl_pkg;

   localparam int KeyCount = 16;

   localparam logic [7:0] RowDrive = 8'hf0;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [3:0] key_idx_type;
   typedef logic [6:0] ascii_type;

   typedef struct packed {
      logic        hit;
      key_idx_type idx;
   } decode_type;

   localparam logic [7:0] KeyCodes [KeyCount] = '{
      8'h77, 8'h7b, 8'h7d, 8'h7e,
      8'hb7, 8'hbb, 8'hbd, 8'hbe,
      8'hd7, 8'hdb, 8'hdd, 8'hde,
      8'he7, 8'heb, 8'hed, 8'hee
   };

   // key order 123A456B789C*0#D
   localparam ascii_type KeyAscii [KeyCount] = '{
      7'h31, 7'h32, 7'h33, 7'h41,
      7'h34, 7'h35, 7'h36, 7'h42,
      7'h37, 7'h38, 7'h39, 7'h43,
      7'h2a, 7'h30, 7'h23, 7'h44
   };

   function automatic decode_type decode_key(input logic [7:0] row, input logic [7:0] col);
      decode_type  res;
      logic [7:0]  code;
      res  = '0;
      code = row | col;
      // codes are distinct, so at most one entry matches
      for (int i = 0; i < KeyCount; i++) begin
         if (KeyCodes[i] == code) begin
            res.hit = 1'b1;
            res.idx = key_idx_type'(i);
         end
      end
      if (row == RowDrive) begin
         res.hit = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/matrix_keypad_scan_latch_top.sv =====
// channel | ports                                     | direction
// --------+-------------------------------------------+----------
// req     | req_valid req_ready req_opcode            | in
//         | req_row_drive_sample req_col_drive_sample |
// rsp     | rsp_valid rsp_ready rsp_key_valid         | out
//         | rsp_key_char rsp_waiting_release          |
//         | rsp_new_key_latched                       |
//
// Each item is held in the input register and then moves to the result register,
// where the decode and key latch update take place in that same step.
// Sustained rate is one item per cycle while rsp_ready is held high.
// The input register doubles as a skid stage: one item is taken while a result waits.
// Reset (synchronous) empties both stages and clears the wait and latch state.
module matrix_keypad_scan_latch_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_row_drive_sample,
   input  logic [7:0] req_col_drive_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_key_valid,
   output logic [6:0] rsp_key_char,
   output logic       rsp_waiting_release,
   output logic       rsp_new_key_latched
);
   import mksl_pkg::*;

   logic        in_valid_ff;
   logic        in_opcode_ff;
   logic [7:0]  in_row_ff;
   logic [7:0]  in_col_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_key_valid_ff, out_key_valid_in;
   ascii_type   out_key_char_ff, out_key_char_in;
   logic        out_new_ff, out_new_in;

   logic        release_wait_ff, release_wait_in;
   key_idx_type candidate_key_ff, candidate_key_in;
   logic        latched_valid_ff, latched_valid_in;
   key_idx_type latched_key_ff, latched_key_in;

   logic        advance;
   decode_type  dec;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign dec = decode_key(in_row_ff, in_col_ff);

   always_comb begin
      release_wait_in  = release_wait_ff;
      candidate_key_in = candidate_key_ff;
      latched_valid_in = latched_valid_ff;
      latched_key_in   = latched_key_ff;
      out_key_valid_in = 1'b0;
      out_key_char_in  = '0;
      out_new_in       = 1'b0;
      out_valid_in     = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = 1'b1;
         if (in_opcode_ff == OP_READ) begin
            if (latched_valid_ff) begin
               out_key_valid_in = 1'b1;
               out_key_char_in  = KeyAscii[latched_key_ff];
            end
            latched_valid_in = 1'b0;
            latched_key_in   = '0;
         end else if (!release_wait_ff) begin
            if (dec.hit) begin
               candidate_key_in = dec.idx;
               release_wait_in  = 1'b1;
            end
         end else if (!dec.hit) begin
            // release: latch the candidate unless it is already latched
            release_wait_in = 1'b0;
            if (!latched_valid_ff || latched_key_ff != candidate_key_ff) begin
               latched_valid_in = 1'b1;
               latched_key_in   = candidate_key_ff;
               out_new_in       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         release_wait_ff  <= 1'b0;
         candidate_key_ff <= '0;
         latched_valid_ff <= 1'b0;
         latched_key_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff     <= out_valid_in;
         release_wait_ff  <= release_wait_in;
         candidate_key_ff <= candidate_key_in;
         latched_valid_ff <= latched_valid_in;
         latched_key_ff   <= latched_key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_row_ff    <= req_row_drive_sample;
         in_col_ff    <= req_col_drive_sample;
      end
      if (advance) begin
         out_key_valid_ff <= out_key_valid_in;
         out_key_char_ff  <= out_key_char_in;
         out_new_ff       <= out_new_in;
      end
   end

   logic out_wait_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_wait_ff <= release_wait_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_key_valid       = out_key_valid_ff;
   assign rsp_key_char        = out_key_char_ff;
   assign rsp_waiting_release = out_wait_ff;
   assign rsp_new_key_latched = out_new_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_new_not_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_key_latched |-> !rsp_key_valid && !rsp_waiting_release)
      else $error("latch result carries read data or pending wait");

   a_key_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_valid |-> rsp_key_char != 7'd0)
      else $error("returned key without character");

   a_new_sets_latch: assert property (@(posedge clock) disable iff (reset)
      advance && out_new_in |=> latched_valid_ff && !release_wait_ff)
      else $error("latch state not updated on new key");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_opcode_ff == OP_READ |=> !latched_valid_ff)
      else $error("host read left latch set");

endmodule
